// File: hdl/lkc_pkg.sv
package lkc_pkg;

	// default number of slots in the row
	localparam int LKC_ENTRIES = 16;

	// capacity register
	localparam int       CAP_W       = 5;
	localparam bit [4:0] CAP_RESET   = 5'd16;

	// request operations
	localparam bit [1:0] OP_ADD      = 2'd0;
	localparam bit [1:0] OP_LOOKUP   = 2'd1;
	localparam bit [1:0] OP_REMOVE   = 2'd2;

	localparam int KEY_W  = 64;

	// metadata words, size in the lowest bits
	typedef struct packed {
		logic [63:0]        inode;
		logic signed [63:0] modified;
		logic signed [63:0] opened;
		logic [63:0]        size;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// update command broadcast to every cell
	typedef struct packed {
		logic insert;    // add miss: place into first free slot, age the rest
		logic evict;     // drop the least recent entry before inserting
		logic promote;   // hit entry goes to rank 0, younger ones age
		logic upd_meta;  // hit entry takes the request metadata
		logic drop;      // hit entry is freed, older ones move up
	} cell_cmd_t;

endpackage

// File: hdl/lkc_cell.sv
module lkc_cell
	import lkc_pkg::*;
#(
	parameter int RANK_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// request broadcast
	input  logic [KEY_W-1:0]  key,
	input  meta_t             meta,
	input  cell_cmd_t         cmd,
	input  logic [RANK_W-1:0] hit_rank,
	input  logic [RANK_W-1:0] vict_rank,
	// chain from the left neighbor
	input  logic              hit_in,
	input  logic [RANK_W-1:0] hit_rank_in,
	input  meta_t             hit_meta_in,
	input  logic              free_in,
	// chain to the right neighbor
	output logic              hit_out,
	output logic [RANK_W-1:0] hit_rank_out,
	output meta_t             hit_meta_out,
	output logic              free_out,
	output logic              valid
);

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic [KEY_W-1:0]  key_q;
	meta_t             meta_q;

	logic match;
	logic victim;
	logic cand;
	logic pick;

	// key compare, merged into the hit chain (at most one cell matches)
	assign match        = valid_q && (key_q == key);
	assign hit_out      = hit_in | match;
	assign hit_rank_out = hit_rank_in | (match ? rank_q : '0);
	assign hit_meta_out = hit_meta_in | (match ? meta_q : '0);

	// first free slot after an optional eviction
	assign victim   = cmd.evict && valid_q && (rank_q == vict_rank);
	assign cand     = !valid_q || victim;
	assign pick     = cmd.insert && cand && !free_in;
	assign free_out = free_in | cand;

	assign valid = valid_q;

	// valid and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.insert) begin
			if (pick) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (victim) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (valid_q) begin
				rank_q  <= rank_q + RANK_W'(1);
			end
		end else if (cmd.promote) begin
			if (match) begin
				rank_q <= '0;
			end else if (valid_q && (rank_q < hit_rank)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end else if (cmd.drop) begin
			if (match) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (valid_q && (rank_q > hit_rank)) begin
				rank_q  <= rank_q - RANK_W'(1);
			end
		end
	end

	// key and metadata
	always_ff @(posedge clk) begin
		if (pick) begin
			key_q  <= key;
			meta_q <= meta;
		end else if (cmd.promote && cmd.upd_meta && match) begin
			meta_q <= meta;
		end
	end

endmodule

// File: hdl/lru_keyed_entry_cache_unit.sv
// Fully associative LRU cache of ENTRIES slots, keyed by a 64-bit key.
// Slave stream: s_tuser carries the operation (add, lookup, remove),
// s_tdata the key and four metadata words. Master stream: m_tuser is the
// ok flag, m_tdata the metadata returned by a lookup hit (zero otherwise).
// Every request gives exactly one result.
// A request is held in the request register while the block is in its
// evaluation state; there the key runs through the row of cells (compare,
// hit merge, first-free search), and when the output register is free all
// cells update rank and contents together and the result is registered.
// No new request is taken until the current one has been committed.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the update for it is held until the output register is
// free. m_tvalid/m_tdata hold while m_tready is low.
// cfg_we/cfg_wdata write the capacity (0 acts as 1, above ENTRIES acts as
// ENTRIES); write it only while the block is idle.
// Reset: all slots invalid, fill count zero, capacity 16, no result
// pending. No clearing pass is needed.
module lru_keyed_entry_cache_unit
	import lkc_pkg::*;
#(
	parameter int ENTRIES = LKC_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [319:0] s_tdata,   // key, file_size, opened_time, modified_time, inode_number
	input  logic [1:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata,   // out_size, out_opened, out_modified, out_inode
	output logic [0:0]   m_tuser,   // ok
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata  // capacity
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic             state_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	meta_t            meta_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] fill_q;
	logic             ok_q;
	meta_t            out_meta_q;

	// cell row chain
	logic [ENTRIES:0]  hit_c;
	logic [ENTRIES:0]  free_c;
	logic [RANK_W-1:0] rank_c [ENTRIES+1];
	meta_t             meta_c [ENTRIES+1];
	logic [ENTRIES-1:0] valid_v;

	logic              commit;
	logic              any_hit;
	logic              is_add;
	logic              is_lookup;
	logic              is_remove;
	logic              full;
	logic [CMP_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  fill_m1;
	logic [RANK_W-1:0] vict_rank;
	cell_cmd_t         cmd;

	assign s_tready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_EVAL) && (!m_tvalid || m_tready);

	assign is_add    = (op_q == OP_ADD);
	assign is_lookup = (op_q == OP_LOOKUP);
	assign is_remove = (op_q == OP_REMOVE);
	assign any_hit   = hit_c[ENTRIES];

	// effective capacity and full check
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end
	assign full      = CMP_W'(fill_q) >= cap_eff;
	assign fill_m1   = fill_q - CNT_W'(1);
	assign vict_rank = fill_m1[RANK_W-1:0];

	// command to the cells; every field but upd_meta only in the update cycle
	always_comb begin
		cmd          = '0;
		cmd.insert   = commit && is_add && !any_hit;
		cmd.evict    = commit && is_add && !any_hit && full;
		cmd.promote  = commit && any_hit && (is_add || is_lookup);
		cmd.upd_meta = is_add;
		cmd.drop     = commit && any_hit && is_remove;
	end

	// row of cells
	assign hit_c[0]  = 1'b0;
	assign free_c[0] = 1'b0;
	assign rank_c[0] = '0;
	assign meta_c[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkc_cell #(
			.RANK_W (RANK_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key          (key_q),
			.meta         (meta_q),
			.cmd          (cmd),
			.hit_rank     (rank_c[ENTRIES]),
			.vict_rank    (vict_rank),
			.hit_in       (hit_c[i]),
			.hit_rank_in  (rank_c[i]),
			.hit_meta_in  (meta_c[i]),
			.free_in      (free_c[i]),
			.hit_out      (hit_c[i+1]),
			.hit_rank_out (rank_c[i+1]),
			.hit_meta_out (meta_c[i+1]),
			.free_out     (free_c[i+1]),
			.valid        (valid_v[i])
		);
	end

	// control: state, capacity, fill count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RESET;
			fill_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.insert && !cmd.evict) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.drop) begin
				fill_q <= fill_m1;
			end
			if (commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[63:0];
			meta_q <= meta_t'(s_tdata[319:64]);
		end
		if (commit) begin
			ok_q       <= is_add || (any_hit && (is_lookup || is_remove));
			out_meta_q <= (is_lookup && any_hit) ? meta_c[ENTRIES] : '0;
		end
	end

	assign m_tdata    = out_meta_q;
	assign m_tuser[0] = ok_q;

	// fill count matches the valid slots
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(fill_q))
		else $error("fill count out of step with valid slots");

	// never more entries than slots
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(ENTRIES))
		else $error("fill count above slot count");

	// an insert always finds a slot
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> free_c[ENTRIES])
		else $error("insert without a free slot");

	// an eviction only happens with a valid least recent entry
	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> (fill_q != '0))
		else $error("eviction with empty cache");

endmodule
